@@ design/integer_matrix_multiply_unit_assert.svh @@
// Assertion macros for the integer matrix multiply unit.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define IMM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define IMM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/imm_pkg.sv @@
// Shared constants, types and helpers for the integer matrix multiply unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package imm_pkg;

  // Matrix geometry.
  localparam int DIM        = 8;
  localparam int FIELD_SPAN = 8;
  localparam int DIM_EFF    = (DIM < FIELD_SPAN) ? DIM : FIELD_SPAN;
  localparam int IDX_W      = 3;
  localparam int SIZE_W     = 4;
  localparam int ADDR_W     = $clog2(DIM * DIM);

  // Datapath widths.
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 38;

  localparam logic [SIZE_W-1:0] DIM_CAP    = SIZE_W'(DIM_EFF);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  // Function codes of an input word.
  localparam logic [1:0] FUNC_LEFT  = 2'd0;
  localparam logic [1:0] FUNC_RIGHT = 2'd1;
  localparam logic [1:0] FUNC_COMP  = 2'd2;

  // Tag that follows each multiply-accumulate step down the pipeline.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_col;
  } imm_tag_t;

  // Element store write request.
  typedef struct packed {
    logic                     we_left;
    logic                     we_right;
    logic [ADDR_W-1:0]        addr;
    logic signed [ELEM_W-1:0] data;
  } imm_wr_t;

  // Element store read addresses for one step.
  typedef struct packed {
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
  } imm_rd_t;

  // Flat store address of element (r, c).
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    int flat;
    flat = int'(r) * DIM + int'(c);
    return ADDR_W'(flat);
  endfunction

endpackage

@@ design/imm_store.sv @@
// Element store: one write port and one registered read port.
// Depends on imm_pkg for the depth and element width.
`timescale 1ns / 1ps

module imm_store (
  input  logic                             clk,
  input  logic                             we,
  input  logic [imm_pkg::ADDR_W-1:0]       waddr,
  input  logic signed [imm_pkg::ELEM_W-1:0] wdata,
  input  logic [imm_pkg::ADDR_W-1:0]       raddr,
  output logic signed [imm_pkg::ELEM_W-1:0] rdata
);
  import imm_pkg::*;

  logic signed [ELEM_W-1:0] mem_r [DIM*DIM];
  logic signed [ELEM_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/imm_mac.sv @@
// Shared multiply-accumulate unit: registered product, then a wide accumulator.
// Depends on imm_pkg for widths and the step tag.
`timescale 1ns / 1ps

module imm_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [imm_pkg::ELEM_W-1:0] a,
  input  logic signed [imm_pkg::ELEM_W-1:0] b,
  input  imm_pkg::imm_tag_t                 tag,
  output logic                              res_strobe,
  output logic [imm_pkg::IDX_W-1:0]         res_row,
  output logic [imm_pkg::IDX_W-1:0]         res_col,
  output logic signed [imm_pkg::ACC_W-1:0]  res_value,
  output logic                              res_last
);
  import imm_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  imm_tag_t                 ptag_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     strobe_r;
  logic [IDX_W-1:0]         row_r;
  logic [IDX_W-1:0]         col_r;
  logic signed [ACC_W-1:0]  value_r;
  logic                     last_r;

  // Product stage.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (!rst_n) begin
      ptag_r <= '0;
    end else begin
      ptag_r <= tag;
    end
  end

  // Accumulate; the first step of a column starts from zero.
  always_comb begin
    acc_nxt = (ptag_r.first ? '0 : acc_r) + ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (ptag_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  // Result register: loaded on the last step of each column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ptag_r.vld && ptag_r.last_k;
    end
    if (ptag_r.vld && ptag_r.last_k) begin
      row_r   <= ptag_r.row;
      col_r   <= ptag_r.col;
      value_r <= acc_nxt;
      last_r  <= ptag_r.last_col;
    end
  end

  assign res_strobe = strobe_r;
  assign res_row    = row_r;
  assign res_col    = col_r;
  assign res_value  = value_r;
  assign res_last   = last_r;

endmodule

@@ design/imm_seq.sv @@
// Sequencer: decodes input words, holds the size register and walks the
// column and inner-product indices of a row. Depends on imm_pkg and the macros.
`timescale 1ns / 1ps
`include "integer_matrix_multiply_unit_assert.svh"

module imm_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [1:0]                        func,
  input  logic [imm_pkg::IDX_W-1:0]         row,
  input  logic [imm_pkg::IDX_W-1:0]         col,
  input  logic signed [imm_pkg::ELEM_W-1:0] value,
  input  logic                              cfg_we,
  input  logic [imm_pkg::SIZE_W-1:0]        cfg_wdata,
  input  logic                              res_strobe,
  input  logic                              res_last,
  output logic                              busy,
  output imm_pkg::imm_wr_t                  wr,
  output imm_pkg::imm_rd_t                  rd,
  output imm_pkg::imm_tag_t                 tag
);
  import imm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [SIZE_W-1:0] n_cur;
  logic              accept;
  logic              row_ok;
  logic              col_ok;
  logic              comp_go;
  logic              last_k;
  logic              last_col;

  // Dimension in use and range checks of the incoming word.
  always_comb begin
    n_cur   = (size_r > DIM_CAP) ? DIM_CAP : size_r;
    accept  = start && !busy;
    row_ok  = SIZE_W'(row) < n_cur;
    col_ok  = SIZE_W'(col) < n_cur;
    comp_go = accept && (func == FUNC_COMP) && row_ok;
  end

  // Element writes go straight to the stores.
  always_comb begin
    wr.we_left  = accept && (func == FUNC_LEFT) && row_ok && col_ok;
    wr.we_right = accept && (func == FUNC_RIGHT) && row_ok && col_ok;
    wr.addr     = elem_addr(row, col);
    wr.data     = value;
  end

  // Step issue: read addresses and the tag for the current (j, k).
  always_comb begin
    last_k       = SIZE_W'(k_r) == (n_r - SIZE_W'(1));
    last_col     = SIZE_W'(j_r) == (n_r - SIZE_W'(1));
    rd.a_addr    = elem_addr(row_r, k_r);
    rd.b_addr    = elem_addr(k_r, j_r);
    tag.vld      = (state_r == ST_RUN);
    tag.first    = (k_r == '0);
    tag.last_k   = last_k;
    tag.row      = row_r;
    tag.col      = j_r;
    tag.last_col = last_col;
  end

  // Next state and index counters.
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    row_nxt   = row_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (comp_go) begin
          state_nxt = ST_RUN;
          n_nxt     = n_cur;
          row_nxt   = row;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          k_nxt = '0;
          if (last_col) begin
            state_nxt = ST_DRAIN;
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (res_strobe && res_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      size_r  <= SIZE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
    n_r   <= n_nxt;
    row_r <= row_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  // Checks on the sequencing.
  `IMM_ASSERT_IMP(a_run_idx, state_r == ST_RUN, (SIZE_W'(k_r) < n_r) && (SIZE_W'(j_r) < n_r), "index out of range")
  `IMM_ASSERT_IMP(a_res_busy, res_strobe, busy, "result word while idle")
  `IMM_ASSERT_NXT(a_go_run, comp_go, state_r == ST_RUN, "accepted row did not start")
  `IMM_ASSERT_NXT(a_final_drain, (state_r == ST_RUN) && last_k && last_col, state_r == ST_DRAIN, "final step did not drain")

endmodule

@@ design/integer_matrix_multiply_unit.sv @@
// Top level of the integer matrix multiply unit.
// Depends on imm_pkg, imm_seq, imm_store and imm_mac.
//
// Usage:
//   An input word is taken at a rising edge with start high and busy low.
//   in_func selects: write left element, write right element, or compute a
//   product row. Element writes leave busy low. Write words with a row or
//   column outside the dimension in use, and compute words with a row outside
//   it, are dropped silently. A compute word for row r gives one result word
//   per column, in column order, each marked by out_strobe for exactly one
//   cycle; out_last marks the final column. The receiver cannot stall; it must
//   take each word as shown. Each step passes through the registered store
//   reads, the product register and the result register. busy stays high
//   until the final result word has been shown. The single shared
//   multiply-accumulate unit does one step per cycle.
//   cfg_we writes cfg_wdata into the size register (reset value 8); write it
//   only while busy is low. Reset puts the sequencer in idle and clears the
//   result strobe; the element stores are undefined until written.
`timescale 1ns / 1ps

module integer_matrix_multiply_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic [imm_pkg::IDX_W-1:0]         in_row,
  input  logic [imm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [imm_pkg::ELEM_W-1:0] in_value,
  input  logic                              cfg_we,
  input  logic [imm_pkg::SIZE_W-1:0]        cfg_wdata,
  output logic                              out_strobe,
  output logic [imm_pkg::IDX_W-1:0]         out_row,
  output logic [imm_pkg::IDX_W-1:0]         out_col,
  output logic signed [imm_pkg::ACC_W-1:0]  out_value,
  output logic                              out_last
);
  import imm_pkg::*;

  imm_wr_t                  wr;
  imm_rd_t                  rd;
  imm_tag_t                 tag;
  imm_tag_t                 tag_rd_r;
  logic signed [ELEM_W-1:0] a_data;
  logic signed [ELEM_W-1:0] b_data;

  // Sequencer.
  imm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .func       (in_func),
    .row        (in_row),
    .col        (in_col),
    .value      (in_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_strobe (out_strobe),
    .res_last   (out_last),
    .busy       (busy),
    .wr         (wr),
    .rd         (rd),
    .tag        (tag)
  );

  // Left and right element stores.
  imm_store u_left (
    .clk   (clk),
    .we    (wr.we_left),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd.a_addr),
    .rdata (a_data)
  );

  imm_store u_right (
    .clk   (clk),
    .we    (wr.we_right),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd.b_addr),
    .rdata (b_data)
  );

  // Tag delayed to line up with the registered store reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_rd_r <= '0;
    end else begin
      tag_rd_r <= tag;
    end
  end

  // Shared multiply-accumulate unit.
  imm_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .a          (a_data),
    .b          (b_data),
    .tag        (tag_rd_r),
    .res_strobe (out_strobe),
    .res_row    (out_row),
    .res_col    (out_col),
    .res_value  (out_value),
    .res_last   (out_last)
  );

endmodule
